>>> design/resource_ownership_table_with_log_defines.svh
// Assertion macros shared by the ownership table design
// Both sample on clk and are disabled while arst_n is low
`ifndef RESOURCE_OWNERSHIP_TABLE_WITH_LOG_DEFINES_SVH
`define RESOURCE_OWNERSHIP_TABLE_WITH_LOG_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define ROT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define ROT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rot_pkg.sv
package rot_pkg;

	// Field widths
	localparam int TYPE_W  = 8;
	localparam int RES_W   = 16;
	localparam int OWN_W   = 16;
	localparam int WANT_W  = 5;
	localparam int NCNT_W  = 5;
	// Most results one log read may produce
	localparam int MAX_OUT = 16;

	// Command codes
	localparam logic CMD_REQ = 1'b0;
	localparam logic CMD_LOG = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_ENTRY  = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	// Top level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REQ,
		ST_LRD,
		ST_LOUT
	} state_t;

	// Table scan sequencer
	typedef enum logic [1:0] {
		TS_CLEAR,
		TS_IDLE,
		TS_SCAN,
		TS_DECIDE
	} tstate_t;

	// One ownership table slot
	typedef struct packed {
		logic [TYPE_W-1:0] type_code;
		logic [RES_W-1:0]  resource;
		logic [OWN_W-1:0]  owner;
	} slot_t;

	// One decision log record
	typedef struct packed {
		logic [TYPE_W-1:0] type_code;
		logic [RES_W-1:0]  resource;
		logic [OWN_W-1:0]  owner;
		logic              granted;
	} rec_t;

	// Sequencer to table
	typedef struct packed {
		logic              go;
		logic [TYPE_W-1:0] type_code;
		logic [RES_W-1:0]  resource;
		logic [OWN_W-1:0]  requester;
	} tbl_req_t;

	// Table to sequencer
	typedef struct packed {
		logic clearing;
		logic done;
		logic granted;
	} tbl_stat_t;

	// Sequencer to log
	typedef struct packed {
		logic              wr;
		rec_t              rec;
		logic              rd_start;
		logic [WANT_W-1:0] want;
		logic              rd_next;
	} log_ctl_t;

	// Log to sequencer
	typedef struct packed {
		logic [NCNT_W-1:0] n_avail;
		rec_t              rec;
	} log_stat_t;

endpackage

>>> design/resource_ownership_table_with_log.sv
// Request: busy from start until the table scan decides; the status is shown the cycle after.
// The time is set by one pass of the shared compare unit over the table, one slot a cycle.
// Log read: per entry ST_LRD (registered memory read), then ST_LOUT; empty read skips both.
// Reset (arst_n low): after release a sweep clears every slot; busy stays high until done.
// Log head and count reset to zero; results cannot be stalled by the receiver.
`include "resource_ownership_table_with_log_defines.svh"

module resource_ownership_table_with_log #(
	parameter int TABLE_ENTRIES = 64,
	parameter int LOG_ENTRIES   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [7:0]  type_code,
	input  logic [15:0] resource,
	input  logic [15:0] requester,
	input  logic [4:0]  max_read,
	output logic        valid,
	output logic [1:0]  kind,
	output logic        granted,
	output logic [7:0]  log_type,
	output logic [15:0] log_resource,
	output logic [15:0] log_owner,
	output logic        log_granted,
	output logic        last
);

	rot_pkg::state_t    state_q, state_d;
	rot_pkg::tbl_req_t  tbl_req;
	rot_pkg::tbl_stat_t tbl_stat;
	rot_pkg::log_ctl_t  log_ctl;
	rot_pkg::log_stat_t log_stat;

	logic accept;

	// latched request
	logic [rot_pkg::TYPE_W-1:0] type_q;
	logic [rot_pkg::RES_W-1:0]  res_q;
	logic [rot_pkg::OWN_W-1:0]  who_q;

	// log read progress
	logic [rot_pkg::NCNT_W-1:0] n_q;
	logic [rot_pkg::NCNT_W-1:0] idx_q;
	logic                       rd_last;

	// output load
	logic           out_load;
	rot_pkg::kind_t out_kind;
	logic           out_granted;
	rot_pkg::rec_t  out_rec;
	logic           out_last;

	// output registers
	logic           valid_q;
	rot_pkg::kind_t kind_q;
	logic           granted_q;
	rot_pkg::rec_t  rec_q;
	logic           last_q;

	// result kind decode for checks
	logic is_status;
	logic is_empty;
	logic is_entry;

	rot_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (tbl_req),
		.stat  (tbl_stat)
	);

	rot_log #(
		.LOG_ENTRIES(LOG_ENTRIES)
	) u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (log_ctl),
		.stat  (log_stat)
	);

	assign busy    = (state_q != rot_pkg::ST_IDLE) || tbl_stat.clearing;
	assign accept  = start && !busy;
	assign rd_last = ((idx_q + rot_pkg::NCNT_W'(1)) == n_q);

	// unit controls
	always_comb begin
		tbl_req.go        = accept && (cmd == rot_pkg::CMD_REQ);
		tbl_req.type_code = type_q;
		tbl_req.resource  = res_q;
		tbl_req.requester = who_q;

		log_ctl.wr            = (state_q == rot_pkg::ST_REQ) && tbl_stat.done;
		log_ctl.rec.type_code = type_q;
		log_ctl.rec.resource  = res_q;
		log_ctl.rec.owner     = who_q;
		log_ctl.rec.granted   = tbl_stat.granted;
		log_ctl.rd_start      = accept && (cmd == rot_pkg::CMD_LOG);
		log_ctl.want          = max_read;
		log_ctl.rd_next       = (state_q == rot_pkg::ST_LOUT);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rot_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and result selection
	always_comb begin
		state_d     = state_q;
		out_load    = 1'b0;
		out_kind    = rot_pkg::KIND_STATUS;
		out_granted = 1'b0;
		out_rec     = '0;
		out_last    = 1'b1;
		case (state_q)
			rot_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd == rot_pkg::CMD_REQ) begin
						state_d = rot_pkg::ST_REQ;
					end else if (log_stat.n_avail == '0) begin
						out_load = 1'b1;
						out_kind = rot_pkg::KIND_EMPTY;
					end else begin
						state_d = rot_pkg::ST_LRD;
					end
				end
			end
			rot_pkg::ST_REQ: begin
				if (tbl_stat.done) begin
					out_load    = 1'b1;
					out_granted = tbl_stat.granted;
					state_d     = rot_pkg::ST_IDLE;
				end
			end
			rot_pkg::ST_LRD: begin
				state_d = rot_pkg::ST_LOUT;
			end
			rot_pkg::ST_LOUT: begin
				out_load = 1'b1;
				out_kind = rot_pkg::KIND_ENTRY;
				out_rec  = log_stat.rec;
				out_last = rd_last;
				state_d  = rd_last ? rot_pkg::ST_IDLE : rot_pkg::ST_LRD;
			end
			default: begin
				state_d = rot_pkg::ST_IDLE;
			end
		endcase
	end

	// result strobe and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			n_q     <= '0;
		end else begin
			valid_q <= out_load;
			if (accept) begin
				idx_q <= '0;
				n_q   <= log_stat.n_avail;
			end else if (state_q == rot_pkg::ST_LOUT) begin
				idx_q <= idx_q + rot_pkg::NCNT_W'(1);
			end
		end
	end

	// request latch and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= type_code;
			res_q  <= resource;
			who_q  <= requester;
		end
		if (out_load) begin
			kind_q    <= out_kind;
			granted_q <= out_granted;
			rec_q     <= out_rec;
			last_q    <= out_last;
		end
	end

	assign valid        = valid_q;
	assign kind         = kind_q;
	assign granted      = granted_q;
	assign log_type     = rec_q.type_code;
	assign log_resource = rec_q.resource;
	assign log_owner    = rec_q.owner;
	assign log_granted  = rec_q.granted;
	assign last         = last_q;

	assign is_status = valid && (kind == rot_pkg::KIND_STATUS);
	assign is_empty  = valid && (kind == rot_pkg::KIND_EMPTY);
	assign is_entry  = valid && (kind == rot_pkg::KIND_ENTRY);

	// checks
	`ROT_ASSERT_IMP(a_status_last, is_status, last, "request status without last")
	`ROT_ASSERT_IMP(a_empty_last, is_empty, last, "empty marker without last")
	`ROT_ASSERT_IMP(a_entry_src, is_entry, $past(state_q) == rot_pkg::ST_LOUT, "stray entry")
	`ROT_ASSERT_IMP(a_done_wait, tbl_stat.done, state_q == rot_pkg::ST_REQ, "stray table done")
	`ROT_ASSERT_NEXT(a_req_busy, tbl_req.go, busy, "request accepted without going busy")

endmodule

>>> design/rot_table.sv
module rot_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rot_pkg::tbl_req_t  req,
	output rot_pkg::tbl_stat_t stat
);

	localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	rot_pkg::tstate_t state_q, state_d;
	logic [CW-1:0]    cnt_q;
	logic             issue;
	logic             clr_last;

	// read pipeline
	logic             rd_v_s1;
	logic [TW-1:0]    rd_idx_s1;
	rot_pkg::slot_t   rd_slot_s1;

	// scan results
	logic                      hit_q;
	logic [rot_pkg::OWN_W-1:0] hit_own_q;
	logic                      free_q;
	logic [TW-1:0]             free_idx_q;

	// write port
	logic           wr_en;
	logic [TW-1:0]  wr_idx;
	rot_pkg::slot_t wr_slot;

	rot_pkg::slot_t table_mem_q [TABLE_ENTRIES];

	logic own_nz;
	logic same_key;

	assign issue    = (cnt_q != CW'(TABLE_ENTRIES));
	assign clr_last = (cnt_q == CW'(TABLE_ENTRIES - 1));
	assign own_nz   = (rd_slot_s1.owner != '0);
	assign same_key = (rd_slot_s1.type_code == req.type_code) &&
		(rd_slot_s1.resource == req.resource);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rot_pkg::TS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, write port and status
	always_comb begin
		state_d          = state_q;
		wr_en            = 1'b0;
		wr_idx           = cnt_q[TW-1:0];
		wr_slot          = '0;
		stat.clearing    = 1'b0;
		stat.done        = 1'b0;
		stat.granted     = 1'b0;
		case (state_q)
			rot_pkg::TS_CLEAR: begin
				stat.clearing = 1'b1;
				wr_en         = 1'b1;
				if (clr_last) begin
					state_d = rot_pkg::TS_IDLE;
				end
			end
			rot_pkg::TS_IDLE: begin
				if (req.go) begin
					state_d = rot_pkg::TS_SCAN;
				end
			end
			rot_pkg::TS_SCAN: begin
				if (!issue && !rd_v_s1) begin
					state_d = rot_pkg::TS_DECIDE;
				end
			end
			rot_pkg::TS_DECIDE: begin
				// owned match wins; else first free slot is taken
				stat.done         = 1'b1;
				stat.granted      = hit_q ? (hit_own_q == req.requester) : free_q;
				wr_en             = !hit_q && free_q;
				wr_idx            = free_idx_q;
				wr_slot.type_code = req.type_code;
				wr_slot.resource  = req.resource;
				wr_slot.owner     = req.requester;
				state_d           = rot_pkg::TS_IDLE;
			end
			default: begin
				state_d = rot_pkg::TS_IDLE;
			end
		endcase
	end

	// scan counter, read valid and compare results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == rot_pkg::TS_SCAN) && issue;
			case (state_q)
				rot_pkg::TS_CLEAR: cnt_q <= clr_last ? '0 : cnt_q + CW'(1);
				rot_pkg::TS_SCAN: if (issue) cnt_q <= cnt_q + CW'(1);
				default: cnt_q <= '0;
			endcase
			if (state_q == rot_pkg::TS_IDLE && req.go) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (rd_v_s1) begin
				if (own_nz && same_key && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!own_nz && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[TW-1:0];
		if (rd_v_s1 && own_nz && same_key && !hit_q) begin
			hit_own_q <= rd_slot_s1.owner;
		end
		if (rd_v_s1 && !own_nz && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem_q[wr_idx] <= wr_slot;
		end
		rd_slot_s1 <= table_mem_q[cnt_q[TW-1:0]];
	end

endmodule

>>> design/rot_log.sv
module rot_log #(
	parameter int LOG_ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rot_pkg::log_ctl_t  ctl,
	output rot_pkg::log_stat_t stat
);

	localparam int LW   = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
	localparam int CNTW = $clog2(LOG_ENTRIES + 1);
	localparam int SW   = LW + 2;
	localparam int CMPW = (CNTW > rot_pkg::NCNT_W) ? CNTW : rot_pkg::NCNT_W;

	logic [LW-1:0]   head_q;
	logic [CNTW-1:0] count_q;
	logic [LW-1:0]   ptr_q;
	rot_pkg::rec_t   rd_rec_q;
	rot_pkg::rec_t   log_mem_q [LOG_ENTRIES];

	logic [SW-1:0]   start_sum;
	logic [LW-1:0]   start_idx;
	logic [CMPW-1:0] cnt_cap;
	logic [CMPW-1:0] want_x;
	logic [CMPW-1:0] n_x;

	// oldest entry: head - count, modulo depth
	always_comb begin
		start_sum = SW'(head_q) + SW'(LOG_ENTRIES) - SW'(count_q);
		if (start_sum >= SW'(LOG_ENTRIES)) begin
			start_sum = start_sum - SW'(LOG_ENTRIES);
		end
		start_idx = start_sum[LW-1:0];
	end

	// entries returned: min(count, want, MAX_OUT)
	always_comb begin
		cnt_cap = CMPW'(count_q);
		if (cnt_cap > CMPW'(rot_pkg::MAX_OUT)) begin
			cnt_cap = CMPW'(rot_pkg::MAX_OUT);
		end
		want_x = CMPW'(ctl.want);
		n_x    = (want_x < cnt_cap) ? want_x : cnt_cap;
	end

	assign stat.n_avail = n_x[rot_pkg::NCNT_W-1:0];
	assign stat.rec     = rd_rec_q;

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (ctl.wr) begin
				head_q <= (head_q == LW'(LOG_ENTRIES - 1)) ? '0 : head_q + LW'(1);
				if (count_q != CNTW'(LOG_ENTRIES)) begin
					count_q <= count_q + CNTW'(1);
				end
			end
			if (ctl.rd_start) begin
				ptr_q <= start_idx;
			end else if (ctl.rd_next) begin
				ptr_q <= (ptr_q == LW'(LOG_ENTRIES - 1)) ? '0 : ptr_q + LW'(1);
			end
		end
	end

	// log memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			log_mem_q[head_q] <= ctl.rec;
		end
		rd_rec_q <= log_mem_q[ptr_q];
	end

endmodule
